FILE: sv/tme_pkg.sv
// ----------------------------------------------------------------------------
// tme_pkg
// types, opcodes and status codes for the tiny machine execute unit
// ----------------------------------------------------------------------------
package tme_pkg;

    localparam int MEM_DEPTH = 2048;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int PC_REG    = 7;

    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_IN   = 5'd1;
    localparam logic [4:0] OP_OUT  = 5'd2;
    localparam logic [4:0] OP_ADD  = 5'd3;
    localparam logic [4:0] OP_SUB  = 5'd4;
    localparam logic [4:0] OP_MUL  = 5'd5;
    localparam logic [4:0] OP_DIV  = 5'd6;
    localparam logic [4:0] OP_LD   = 5'd8;
    localparam logic [4:0] OP_ST   = 5'd9;
    localparam logic [4:0] OP_LDA  = 5'd11;
    localparam logic [4:0] OP_LDC  = 5'd12;
    localparam logic [4:0] OP_JLT  = 5'd13;
    localparam logic [4:0] OP_JLE  = 5'd14;
    localparam logic [4:0] OP_JGT  = 5'd15;
    localparam logic [4:0] OP_JGE  = 5'd16;
    localparam logic [4:0] OP_JEQ  = 5'd17;
    localparam logic [4:0] OP_JNE  = 5'd18;

    localparam logic [2:0] ST_CONT  = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_MEM   = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    typedef struct packed {
        logic        [4:0]  req_type;
        logic        [2:0]  reg_a;
        logic signed [31:0] arg_b;
        logic        [2:0]  reg_c;
        logic signed [31:0] in_value;
    } t_req;

    typedef struct packed {
        logic        [2:0]  status;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic signed [31:0] next_pc;
    } t_rsp;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_cmd;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_alu_rsp;

endpackage

FILE: sv/tiny_machine_execute_top.sv
// ----------------------------------------------------------------------------
// tiny_machine_execute_top
// executes one decoded tiny machine instruction per input word
// ----------------------------------------------------------------------------
// channel  direction  payload  handshake
// req      in         t_req    i_req_valid / o_req_ready
// rsp      out        t_rsp    o_rsp_valid / i_rsp_ready
// most instructions pass through three states: accept and register read, execute, done
// ld adds a memory state for the registered memory read
// mul and div wait in the alu state for 32 shift steps on the shared unit
// after reset a clearing pass writes all MEM_DEPTH memory words (word 0 gets MEM_DEPTH-1)
// a result waits in the output register while the next word executes
// the done state holds until the output register is free
// ----------------------------------------------------------------------------
module tiny_machine_execute_top import tme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_ALU, S_MEM, S_DONE} t_state;

    t_state      r_state;
    t_req        r_req;
    logic [31:0] r_regs [8];
    logic [MEM_AW:0] r_clr;
    logic [31:0] r_vs, r_vt, r_vr, r_m;
    logic [2:0]  r_status;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    t_alu_cmd    alu_cmd;
    t_alu_rsp    alu_rsp;
    logic        mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [31:0] mem_wdata, mem_rdata;
    logic        in_bounds;
    logic        take;
    logic [31:0] pc_inc;
    logic [2:0]  exec_status;
    t_state      exec_next;
    logic        out_free;

    assign o_req_ready = (r_state == S_IDLE);
    assign in_bounds   = !r_m[31] && (r_m < 32'(MEM_DEPTH));
    assign pc_inc      = r_regs[PC_REG] + 32'd1;
    assign out_free    = !o_rsp_valid || i_rsp_ready;

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_m[MEM_AW-1:0];
        mem_wdata = r_vr;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr[MEM_AW-1:0];
            mem_wdata = (r_clr == '0) ? 32'(MEM_DEPTH - 1) : 32'd0;
        end else if (r_state == S_EXEC && r_req.req_type == OP_ST && in_bounds) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        alu_cmd.start  = (r_state == S_EXEC) &&
                         (r_req.req_type == OP_MUL ||
                          (r_req.req_type == OP_DIV && r_vt != 32'd0));
        alu_cmd.is_div = (r_req.req_type == OP_DIV);
        alu_cmd.a      = r_vs;
        alu_cmd.b      = r_vt;
    end

    always_comb begin
        unique case (r_req.req_type)
            OP_JLT:  take = r_vr[31];
            OP_JLE:  take = r_vr[31] || r_vr == 32'd0;
            OP_JGT:  take = !r_vr[31] && r_vr != 32'd0;
            OP_JGE:  take = !r_vr[31];
            OP_JEQ:  take = r_vr == 32'd0;
            OP_JNE:  take = r_vr != 32'd0;
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        exec_status = ST_CONT;
        exec_next   = S_DONE;
        case (r_req.req_type) inside
            OP_HALT: exec_status = ST_HALT;
            OP_IN, OP_OUT, OP_ADD, OP_SUB, OP_LDA, OP_LDC,
            OP_JLT, OP_JLE, OP_JGT, OP_JGE, OP_JEQ, OP_JNE: exec_status = ST_CONT;
            OP_MUL:  exec_next = S_ALU;
            OP_DIV: begin
                if (r_vt == 32'd0) begin
                    exec_status = ST_DIV0;
                end else begin
                    exec_next = S_ALU;
                end
            end
            OP_LD, OP_ST: begin
                if (!in_bounds) begin
                    exec_status = ST_MEM;
                end else if (r_req.req_type == OP_LD) begin
                    exec_next = S_MEM;
                end
            end
            default: exec_status = ST_BAD;
        endcase
    end

    tme_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (alu_cmd),
        .o_rsp  (alu_rsp)
    );

    tme_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            o_rsp_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (o_rsp_valid && i_rsp_ready && r_state != S_DONE) begin
                o_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (MEM_AW+1)'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        // pc increment first; operands see the new pc
                        r_req          <= i_req;
                        r_regs[PC_REG] <= pc_inc;
                        r_vs <= (i_req.arg_b[2:0] == 3'(PC_REG)) ? pc_inc
                                : r_regs[i_req.arg_b[2:0]];
                        r_vt <= (i_req.reg_c == 3'(PC_REG)) ? pc_inc : r_regs[i_req.reg_c];
                        r_vr <= (i_req.reg_a == 3'(PC_REG)) ? pc_inc : r_regs[i_req.reg_a];
                        r_m  <= i_req.arg_b + ((i_req.reg_c == 3'(PC_REG)) ? pc_inc
                                : r_regs[i_req.reg_c]);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status    <= exec_status;
                    r_out_valid <= (r_req.req_type == OP_OUT);
                    r_out_value <= (r_req.req_type == OP_OUT) ? r_vr : 32'd0;
                    r_state     <= exec_next;
                    case (r_req.req_type) inside
                        OP_IN:   r_regs[r_req.reg_a] <= r_req.in_value;
                        OP_ADD:  r_regs[r_req.reg_a] <= r_vs + r_vt;
                        OP_SUB:  r_regs[r_req.reg_a] <= r_vs - r_vt;
                        OP_LDA:  r_regs[r_req.reg_a] <= r_m;
                        OP_LDC:  r_regs[r_req.reg_a] <= r_req.arg_b;
                        OP_JLT, OP_JLE, OP_JGT, OP_JGE, OP_JEQ, OP_JNE: begin
                            if (take) begin
                                r_regs[PC_REG] <= r_m;
                            end
                        end
                        default: ;
                    endcase
                end
                S_ALU: begin
                    if (alu_rsp.done) begin
                        r_regs[r_req.reg_a] <= alu_rsp.result;
                        r_state             <= S_DONE;
                    end
                end
                S_MEM: begin
                    r_regs[r_req.reg_a] <= mem_rdata;
                    r_state             <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_rsp.status    <= r_status;
                        o_rsp.out_valid <= r_out_valid;
                        o_rsp.out_value <= r_out_value;
                        o_rsp.next_pc   <= r_regs[PC_REG];
                        o_rsp_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("pending result changed");
    a_done_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && out_free |=> o_rsp_valid && r_state == S_IDLE)
        else $error("result not presented");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> r_state == S_EXEC)
        else $error("accepted word not executed");
endmodule

FILE: sv/tme_ram.sv
// ----------------------------------------------------------------------------
// tme_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module tme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: sv/tme_alu.sv
// ----------------------------------------------------------------------------
// tme_alu
// shared multi-cycle unit: shift-add multiply and restoring signed divide
// ----------------------------------------------------------------------------
module tme_alu import tme_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_cmd i_cmd,
    output t_alu_rsp o_rsp
);
    logic        r_busy, n_busy;
    logic        r_div, n_div;
    logic        r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic        r_done, n_done;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    always_comb begin
        n_busy = r_busy;
        n_div  = r_div;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_done = 1'b0;
        rem_sh  = {r_acc, r_x[31]};
        rem_sub = rem_sh - {1'b0, r_y};
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_div  = i_cmd.is_div;
            n_cnt  = 6'd0;
            n_acc  = '0;
            if (i_cmd.is_div) begin
                n_neg = i_cmd.a[31] ^ i_cmd.b[31];
                n_x   = i_cmd.a[31] ? 32'd0 - i_cmd.a : i_cmd.a;
                n_y   = i_cmd.b[31] ? 32'd0 - i_cmd.b : i_cmd.b;
            end else begin
                n_neg = 1'b0;
                n_x   = i_cmd.a;
                n_y   = i_cmd.b;
            end
        end else if (r_busy) begin
            if (r_div) begin
                // quotient bits shift into x, remainder in acc
                if (!rem_sub[32]) begin
                    n_acc = rem_sub[31:0];
                    n_x   = {r_x[30:0], 1'b1};
                end else begin
                    n_acc = rem_sh[31:0];
                    n_x   = {r_x[30:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x = {r_x[30:0], 1'b0};
                n_y = {1'b0, r_y[31:1]};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_div <= n_div;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_div) begin
            o_rsp.result = r_neg ? 32'd0 - r_x : r_x;
        end else begin
            o_rsp.result = r_acc;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("alu done while busy");
    a_cnt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_cmd.start && r_cnt == 6'd31 |=> r_done)
        else $error("alu did not finish");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("alu restarted while busy");
endmodule
